@@ src/fsqt_pkg.sv @@
package fsqt_pkg;

  localparam int TIME_W     = 40;
  localparam int DUR_W      = 21;
  localparam int POS_W      = 18;
  localparam int VEL_W      = 25;
  localparam int ACC_W      = 32;
  localparam int RES_W      = 1 + 3 * POS_W + 3 * VEL_W + 3 * ACC_W;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 232;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  localparam int T_DIV_NW = DUR_W + 30;
  localparam int T_DIV_QW = 30;
  localparam int R_DIV_NW = 64;
  localparam int R_DIV_QW = 49;

  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [30:0] Q30_HALF = 31'h2000_0000;
  localparam logic [DUR_W-1:0] MIN_DUR = 21'd50000;
  localparam logic [20:0] K_XY = 21'd1000000;
  localparam logic [20:0] K_Z  = 21'd2000000;
  localparam logic signed [20:0] APEX_CLEARANCE = 21'sd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X,
    CFG_START_Y,
    CFG_START_Z,
    CFG_GOAL_X,
    CFG_GOAL_Y,
    CFG_GOAL_Z,
    CFG_START_TIME,
    CFG_DURATION
  } cfg_idx_e;

endpackage

@@ src/fsqt_div.sv @@
module fsqt_div #(
  parameter int NW  = 64,
  parameter int QW  = 49,
  parameter int DW  = 21,
  parameter int LN  = 1,
  parameter int SBW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LN-1:0][NW-1:0]      num_i,
  input  logic [SBW-1:0]             side_i,
  input  logic [DW-1:0]              den_i,
  output logic                       valid_o,
  output logic [LN-1:0][QW-1:0]      quot_o,
  output logic [SBW-1:0]             side_o
);

  logic [LN-1:0][DW-1:0] rem_q [QW];
  logic [LN-1:0][QW-1:0] low_q [QW];
  logic [LN-1:0][QW-1:0] quo_q [QW];
  logic [SBW-1:0]        sb_q  [QW];
  logic                  v_q   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [LN-1:0][DW-1:0] rem_p, rem_d;
    logic [LN-1:0][QW-1:0] low_p, low_d, quo_p, quo_d;
    logic [SBW-1:0]        sb_p;
    logic                  v_p;

    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LN; l++) begin
          rem_p[l] = DW'(num_i[l][NW-1:QW]);
          low_p[l] = num_i[l][QW-1:0];
          quo_p[l] = '0;
        end
      end
      assign sb_p = side_i;
      assign v_p  = valid_i;
    end else begin : g_next
      assign rem_p = rem_q[s-1];
      assign low_p = low_q[s-1];
      assign quo_p = quo_q[s-1];
      assign sb_p  = sb_q[s-1];
      assign v_p   = v_q[s-1];
    end

    always_comb begin
      logic [DW:0] r2;
      for (int l = 0; l < LN; l++) begin
        r2 = {rem_p[l], low_p[l][QW-1]};
        if (r2 >= {1'b0, den_i}) begin
          rem_d[l] = DW'(r2 - {1'b0, den_i});
          quo_d[l] = {quo_p[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = r2[DW-1:0];
          quo_d[l] = {quo_p[l][QW-2:0], 1'b0};
        end
        low_d[l] = {low_p[l][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
        sb_q[s]  <= sb_p;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = quo_q[QW-1];
  assign side_o  = sb_q[QW-1];

endmodule

@@ src/foot_swing_quintic_trajectory_unit.sv @@
// throughput: one item per cycle unless the output buffer is full; the phase
// divider (30 stages) and the two rate dividers (49 stages each) are fully
// pipelined, one quotient bit per stage
// a two-entry output buffer holds results; input stalls only when it is full
// reset: async active low, clears all valid bits and config registers to zero
module foot_swing_quintic_trajectory_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fsqt_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // now_time
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // valid_res, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
  output logic [fsqt_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fsqt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fsqt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {PH_ZERO, PH_ONE, PH_MID} ph_e;

  typedef struct packed {
    logic ok;
    ph_e  ph;
  } ts_t;

  typedef struct packed {
    logic        ok;
    logic        fh;
    logic [30:0] t, t2, t3, t4, t5;
    logic [30:0] h, h2, h3, h4, h5;
  } pw_t;

  typedef struct packed {
    logic signed [39:0] p;
    logic signed [39:0] v;
    logic signed [39:0] a;
  } shp_t;

  typedef struct packed {
    logic ok;
    logic fh;
    shp_t st;
    shp_t sh;
  } sh_t;

  typedef struct packed {
    logic              ok;
    logic [2:0][60:0]  pp, pv, pa;
    logic [20:0]       zb;
  } pr_t;

  typedef struct packed {
    logic                            ok;
    logic [2:0][fsqt_pkg::POS_W-1:0] pos;
    logic [2:0]                      nv, na;
    logic [2:0][60:0]                mv, ma;
  } mg_t;

  typedef struct packed {
    logic                            ok;
    logic [2:0][fsqt_pkg::POS_W-1:0] pos;
    logic [2:0]                      nv, na;
  } sa_t;

  typedef struct packed {
    logic                            ok;
    logic [2:0][fsqt_pkg::POS_W-1:0] pos;
    logic [2:0][fsqt_pkg::VEL_W-1:0] vel;
    logic [2:0]                      na;
  } sb_t;

  function automatic logic [30:0] f_qmul(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] pr;
    pr = a * b;
    return pr[60:30];
  endfunction

  function automatic shp_t f_shapes(input logic [30:0] t, input logic [30:0] t2,
                                    input logic [30:0] t3, input logic [30:0] t4,
                                    input logic [30:0] t5);
    logic signed [39:0] s1, s2, s3, s4, s5, p;
    shp_t r;
    s1 = $signed(40'(t));
    s2 = $signed(40'(t2));
    s3 = $signed(40'(t3));
    s4 = $signed(40'(t4));
    s5 = $signed(40'(t5));
    p = 40'sd10 * s3 - 40'sd15 * s4 + 40'sd6 * s5;
    if (p < 40'sd0) p = 40'sd0;
    if (p > $signed(40'(fsqt_pkg::Q30_ONE))) p = $signed(40'(fsqt_pkg::Q30_ONE));
    r.p = p;
    r.v = 40'sd30 * s2 - 40'sd60 * s3 + 40'sd30 * s4;
    r.a = 40'sd60 * s1 - 40'sd180 * s2 + 40'sd120 * s3;
    return r;
  endfunction

  function automatic logic [60:0] f_abs(input logic [60:0] x);
    return x[60] ? 61'd0 - x : x;
  endfunction

  function automatic logic [fsqt_pkg::VEL_W-1:0] f_satv(input logic neg,
                                                       input logic [48:0] q);
    logic [32:0] m;
    m = q[48:16];
    if (neg) begin
      return (m > 33'd16777216) ? 25'h100_0000 : 25'd0 - m[24:0];
    end
    return (m > 33'd16777215) ? 25'h0FF_FFFF : m[24:0];
  endfunction

  function automatic logic [fsqt_pkg::ACC_W-1:0] f_sata(input logic neg,
                                                       input logic [48:0] q);
    logic [38:0] m;
    m = q[48:10];
    if (neg) begin
      return (m > 39'd2147483648) ? 32'h8000_0000 : 32'd0 - m[31:0];
    end
    return (m > 39'd2147483647) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  // configuration registers
  logic signed [17:0]                sx_q, sy_q, sz_q, gx_q, gy_q, gz_q;
  logic [fsqt_pkg::TIME_W-1:0]       t0_q;
  logic [fsqt_pkg::DUR_W-1:0]        dur_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q  <= '0;
      sy_q  <= '0;
      sz_q  <= '0;
      gx_q  <= '0;
      gy_q  <= '0;
      gz_q  <= '0;
      t0_q  <= '0;
      dur_q <= '0;
    end else if (cfg_valid_i) begin
      case (fsqt_pkg::cfg_idx_e'(cfg_index_i))
        fsqt_pkg::CFG_START_X:    sx_q  <= cfg_data_i[17:0];
        fsqt_pkg::CFG_START_Y:    sy_q  <= cfg_data_i[17:0];
        fsqt_pkg::CFG_START_Z:    sz_q  <= cfg_data_i[17:0];
        fsqt_pkg::CFG_GOAL_X:     gx_q  <= cfg_data_i[17:0];
        fsqt_pkg::CFG_GOAL_Y:     gy_q  <= cfg_data_i[17:0];
        fsqt_pkg::CFG_GOAL_Z:     gz_q  <= cfg_data_i[17:0];
        fsqt_pkg::CFG_START_TIME: t0_q  <= cfg_data_i[fsqt_pkg::TIME_W-1:0];
        fsqt_pkg::CFG_DURATION:   dur_q <= cfg_data_i[fsqt_pkg::DUR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [fsqt_pkg::DUR_W-1:0] dur_eff;
  logic                       cfg_ok;
  logic signed [20:0]         dx, dy, apex, dz_up, dz_dn;

  assign dur_eff = (dur_q < fsqt_pkg::MIN_DUR) ? fsqt_pkg::MIN_DUR : dur_q;
  assign cfg_ok  = (dur_q != '0);
  assign dx      = 21'(gx_q) - 21'(sx_q);
  assign dy      = 21'(gy_q) - 21'(sy_q);
  assign apex    = ((sz_q > gz_q) ? 21'(sz_q) : 21'(gz_q)) + fsqt_pkg::APEX_CLEARANCE;
  assign dz_up   = apex - 21'(sz_q);
  assign dz_dn   = 21'(gz_q) - apex;

  // pipeline advance
  logic [1:0] cnt_q;
  logic       en;
  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;

  // input register
  logic                        v1_q;
  logic [fsqt_pkg::TIME_W-1:0] now1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) now1_q <= s_axis_tdata[fsqt_pkg::TIME_W-1:0];
  end

  // phase
  logic [fsqt_pkg::TIME_W:0]   dt_full;
  logic                        t_before, t_after;
  logic [fsqt_pkg::DUR_W-1:0]  dt_mid;
  ts_t                         ts_i, ts_o;
  logic                        tv;
  logic [0:0][fsqt_pkg::T_DIV_NW-1:0] t_num;
  logic [0:0][fsqt_pkg::T_DIV_QW-1:0] t_quo;

  always_comb begin
    dt_full  = {1'b0, now1_q} - {1'b0, t0_q};
    t_before = (now1_q <= t0_q);
    t_after  = !t_before && (dt_full[fsqt_pkg::TIME_W-1:0] >= fsqt_pkg::TIME_W'(dur_eff));
    dt_mid   = (t_before || t_after) ? '0 : dt_full[fsqt_pkg::DUR_W-1:0];
    ts_i.ok  = cfg_ok;
    ts_i.ph  = t_before ? PH_ZERO : (t_after ? PH_ONE : PH_MID);
    t_num[0] = {dt_mid, 30'd0};
  end

  fsqt_div #(
    .NW (fsqt_pkg::T_DIV_NW),
    .QW (fsqt_pkg::T_DIV_QW),
    .DW (fsqt_pkg::DUR_W),
    .LN (1),
    .SBW($bits(ts_t))
  ) u_tdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v1_q),
    .num_i  (t_num),
    .side_i (ts_i),
    .den_i  (dur_eff),
    .valid_o(tv),
    .quot_o (t_quo),
    .side_o (ts_o)
  );

  // powers of t and of the half phase
  pw_t        pw_q [5];
  pw_t        pw_d [5];
  logic [4:0] pv_q;

  always_comb begin
    logic [30:0] t, tm;
    case (ts_o.ph)
      PH_ZERO: t = '0;
      PH_ONE:  t = fsqt_pkg::Q30_ONE;
      default: t = {1'b0, t_quo[0]};
    endcase
    tm = t - fsqt_pkg::Q30_HALF;
    pw_d[0]    = '0;
    pw_d[0].ok = ts_o.ok;
    pw_d[0].fh = (t < fsqt_pkg::Q30_HALF);
    pw_d[0].t  = t;
    pw_d[0].h  = pw_d[0].fh ? {t[29:0], 1'b0} : {tm[29:0], 1'b0};
    pw_d[1]    = pw_q[0];
    pw_d[1].t2 = f_qmul(pw_q[0].t, pw_q[0].t);
    pw_d[1].h2 = f_qmul(pw_q[0].h, pw_q[0].h);
    pw_d[2]    = pw_q[1];
    pw_d[2].t3 = f_qmul(pw_q[1].t2, pw_q[1].t);
    pw_d[2].h3 = f_qmul(pw_q[1].h2, pw_q[1].h);
    pw_d[3]    = pw_q[2];
    pw_d[3].t4 = f_qmul(pw_q[2].t3, pw_q[2].t);
    pw_d[3].h4 = f_qmul(pw_q[2].h3, pw_q[2].h);
    pw_d[4]    = pw_q[3];
    pw_d[4].t5 = f_qmul(pw_q[3].t4, pw_q[3].t);
    pw_d[4].h5 = f_qmul(pw_q[3].h4, pw_q[3].h);
  end

  // shapes, products, magnitudes, rate numerators
  sh_t              sh_q, sh_d;
  pr_t              pr_q, pr_d;
  mg_t              mg_q, mg_d;
  sa_t              sa_q, sa_d;
  logic [5:0][63:0] num_q, num_d;
  logic             shv_q, prv_q, mgv_q, nmv_q;

  always_comb begin
    sh_d.ok = pw_q[4].ok;
    sh_d.fh = pw_q[4].fh;
    sh_d.st = f_shapes(pw_q[4].t, pw_q[4].t2, pw_q[4].t3, pw_q[4].t4, pw_q[4].t5);
    sh_d.sh = f_shapes(pw_q[4].h, pw_q[4].h2, pw_q[4].h3, pw_q[4].h4, pw_q[4].h5);
  end

  always_comb begin
    shp_t               sp;
    logic signed [20:0] d;
    pr_d.ok = sh_q.ok;
    pr_d.zb = sh_q.fh ? 21'(sz_q) : apex;
    for (int i = 0; i < 3; i++) begin
      sp = (i == 2) ? sh_q.sh : sh_q.st;
      d  = (i == 0) ? dx : ((i == 1) ? dy : (sh_q.fh ? dz_up : dz_dn));
      pr_d.pp[i] = 61'(sp.p) * 61'(d);
      pr_d.pv[i] = 61'(sp.v) * 61'(d);
      pr_d.pa[i] = 61'(sp.a) * 61'(d);
    end
  end

  always_comb begin
    logic [60:0]        mp;
    logic signed [33:0] offs, sum;
    logic signed [20:0] base;
    mg_d.ok = pr_q.ok;
    for (int i = 0; i < 3; i++) begin
      mp   = f_abs(pr_q.pp[i]);
      offs = $signed(34'(mp[60:30]));
      if (pr_q.pp[i][60]) offs = -offs;
      base = (i == 0) ? 21'(sx_q) : ((i == 1) ? 21'(sy_q) : $signed(pr_q.zb));
      sum  = 34'(base) + offs;
      if (i < 2) begin
        mg_d.pos[i] = sum[17:0];
      end else if (sum > 34'sd131071) begin
        mg_d.pos[i] = 18'h1FFFF;
      end else if (sum < -34'sd131072) begin
        mg_d.pos[i] = 18'h20000;
      end else begin
        mg_d.pos[i] = sum[17:0];
      end
      mg_d.nv[i] = pr_q.pv[i][60];
      mg_d.na[i] = pr_q.pa[i][60];
      mg_d.mv[i] = f_abs(pr_q.pv[i]);
      mg_d.ma[i] = f_abs(pr_q.pa[i]);
    end
  end

  always_comb begin
    logic [67:0] pv68;
    logic [61:0] pa62;
    logic [20:0] kk;
    sa_d.ok  = mg_q.ok;
    sa_d.pos = mg_q.pos;
    sa_d.nv  = mg_q.nv;
    sa_d.na  = mg_q.na;
    for (int i = 0; i < 3; i++) begin
      kk           = (i == 2) ? fsqt_pkg::K_Z : fsqt_pkg::K_XY;
      pv68         = 68'(mg_q.mv[i][60:14]) * 68'(kk);
      pa62         = 62'(mg_q.ma[i][60:20]) * 62'(kk);
      num_d[i]     = pv68[63:0];
      num_d[i + 3] = 64'(pa62);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      shv_q <= 1'b0;
      prv_q <= 1'b0;
      mgv_q <= 1'b0;
      nmv_q <= 1'b0;
    end else if (en) begin
      pv_q  <= {pv_q[3:0], tv};
      shv_q <= pv_q[4];
      prv_q <= shv_q;
      mgv_q <= prv_q;
      nmv_q <= mgv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 5; k++) pw_q[k] <= pw_d[k];
      sh_q  <= sh_d;
      pr_q  <= pr_d;
      mg_q  <= mg_d;
      sa_q  <= sa_d;
      num_q <= num_d;
    end
  end

  // velocity and first acceleration division
  logic                                va;
  logic [5:0][fsqt_pkg::R_DIV_QW-1:0]  qa;
  sa_t                                 sa_o;

  fsqt_div #(
    .NW (fsqt_pkg::R_DIV_NW),
    .QW (fsqt_pkg::R_DIV_QW),
    .DW (fsqt_pkg::DUR_W),
    .LN (6),
    .SBW($bits(sa_t))
  ) u_adiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(nmv_q),
    .num_i  (num_q),
    .side_i (sa_q),
    .den_i  (dur_eff),
    .valid_o(va),
    .quot_o (qa),
    .side_o (sa_o)
  );

  sb_t              sb_q, sb_d;
  logic [2:0][63:0] num2_q, num2_d;
  logic             s12v_q;

  always_comb begin
    logic [69:0] pr70;
    logic [20:0] kk;
    sb_d.ok  = sa_o.ok;
    sb_d.pos = sa_o.pos;
    sb_d.na  = sa_o.na;
    for (int i = 0; i < 3; i++) begin
      kk          = (i == 2) ? fsqt_pkg::K_Z : fsqt_pkg::K_XY;
      sb_d.vel[i] = f_satv(sa_o.nv[i], qa[i]);
      pr70        = 70'(qa[i + 3]) * 70'(kk);
      num2_d[i]   = pr70[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12v_q <= 1'b0;
    end else if (en) begin
      s12v_q <= va;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q   <= sb_d;
      num2_q <= num2_d;
    end
  end

  // second acceleration division
  logic                                vb;
  logic [2:0][fsqt_pkg::R_DIV_QW-1:0]  qb;
  sb_t                                 sb_o;

  fsqt_div #(
    .NW (fsqt_pkg::R_DIV_NW),
    .QW (fsqt_pkg::R_DIV_QW),
    .DW (fsqt_pkg::DUR_W),
    .LN (3),
    .SBW($bits(sb_t))
  ) u_bdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s12v_q),
    .num_i  (num2_q),
    .side_i (sb_q),
    .den_i  (dur_eff),
    .valid_o(vb),
    .quot_o (qb),
    .side_o (sb_o)
  );

  logic [fsqt_pkg::RES_W-1:0] res;

  always_comb begin
    logic [2:0][fsqt_pkg::ACC_W-1:0] acc;
    for (int i = 0; i < 3; i++) acc[i] = f_sata(sb_o.na[i], qb[i]);
    if (sb_o.ok) begin
      res = {acc[2], acc[1], acc[0], sb_o.vel[2], sb_o.vel[1], sb_o.vel[0],
             sb_o.pos[2], sb_o.pos[1], sb_o.pos[0], 1'b1};
    end else begin
      res = '0;
    end
  end

  // output buffer
  logic [fsqt_pkg::RES_W-1:0] fifo_q [2];
  logic                       wp_q, rp_q;
  logic                       push, pop;

  assign push          = en && vb;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {(fsqt_pkg::M_TDATA_W - fsqt_pkg::RES_W)'(0), fifo_q[rp_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= res;
  end

endmodule

@@ src/fsqt_chk.sv @@
module fsqt_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fsqt_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_unconf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[fsqt_pkg::RES_W-1:1] == '0)
    else $error("unconfigured result not zero");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[fsqt_pkg::M_TDATA_W-1:fsqt_pkg::RES_W] == '0)
    else $error("padding bits set");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

endmodule

bind foot_swing_quintic_trajectory_unit fsqt_chk u_fsqt_chk (.*);
